### sv/i2c_master_register_block_core_assert.svh
// Assertion macros for the I2C master register block checker.
// Used by i2cm_checker.sv; no other dependencies.
`ifndef I2C_MASTER_REGISTER_BLOCK_CORE_ASSERT_SVH
`define I2C_MASTER_REGISTER_BLOCK_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define I2CM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/i2cm_pkg.sv
// Types, register offsets and codes of the I2C master register block.
// No dependencies; used by the core and its checker.
`default_nettype none

package i2cm_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RECV  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_START      = 3'd1,
        ACT_START_STOP = 3'd2,
        ACT_SEND       = 3'd3,
        ACT_RECV       = 3'd4,
        ACT_DISCARD    = 3'd5,
        ACT_STOP       = 3'd6
    } bus_action_t;

    typedef struct packed {
        op_t         operation;
        logic [11:0] reg_offset;
        logic [31:0] write_value;
        logic        target_acked;
        logic [7:0]  received_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        interrupt_line;
        bus_action_t bus_action;
        logic [7:0]  bus_byte;
        logic [8:0]  receive_count;
    } out_item_t;

    // register offsets
    localparam logic [11:0] OFS_VERSION = 12'h000;
    localparam logic [11:0] OFS_PARAM   = 12'h004;
    localparam logic [11:0] OFS_CTRL    = 12'h010;
    localparam logic [11:0] OFS_STATUS  = 12'h014;
    localparam logic [11:0] OFS_IEN     = 12'h018;
    localparam logic [11:0] OFS_CFG0    = 12'h020;
    localparam logic [11:0] OFS_CFG1    = 12'h024;
    localparam logic [11:0] OFS_CFG2    = 12'h028;
    localparam logic [11:0] OFS_CCFG0   = 12'h048;
    localparam logic [11:0] OFS_CCFG1   = 12'h050;
    localparam logic [11:0] OFS_FCTRL   = 12'h058;
    localparam logic [11:0] OFS_FSTAT   = 12'h05C;
    localparam logic [11:0] OFS_TXDATA  = 12'h060;
    localparam logic [11:0] OFS_RXDATA  = 12'h070;

    // command field of a transmit data write
    localparam logic [2:0] CMD_SEND       = 3'd0;
    localparam logic [2:0] CMD_RECV       = 3'd1;
    localparam logic [2:0] CMD_STOP       = 3'd2;
    localparam logic [2:0] CMD_DISCARD    = 3'd3;
    localparam logic [2:0] CMD_START      = 3'd4;
    localparam logic [2:0] CMD_START_STOP = 3'd6;

    localparam logic [31:0] VERSION_VALUE = 32'h0104_0001;
    localparam logic [63:0] PARAM_WIDE    = (64'(FIFO_DEPTH) << 24) |
                                            (64'(FIFO_DEPTH) << 16) | 64'd2;
    localparam logic [31:0] PARAM_VALUE   = PARAM_WIDE[31:0];
    localparam logic [31:0] RX_EMPTY_DATA = 32'h0000_4000;

    localparam logic [31:0] ST_TDF   = 32'h0000_0001;
    localparam logic [31:0] ST_RDF   = 32'h0000_0002;
    localparam logic [31:0] ST_NDF   = 32'h0000_0020;
    localparam logic [31:0] ST_EPF   = 32'h0000_0100;
    localparam logic [31:0] ST_BUSF  = 32'h0200_0000;
    localparam logic [31:0] ST_W1C   = 32'h0000_27E0;
    localparam logic [31:0] ST_RESET = ST_TDF | ST_EPF | ST_BUSF;

    localparam logic [31:0] CTRL_CLR_MASK  = 32'h0000_0302;
    localparam int          CTRL_EN_BIT    = 0;
    localparam int          CTRL_RST_BIT   = 1;
    localparam int          CTRL_RXFLUSH_BIT = 8;
    localparam logic [31:0] IEN_MASK       = 32'h0000_0303;
    localparam logic [31:0] FCTRL_MASK     = 32'h0003_0003;

endpackage

`default_nettype wire

### sv/i2c_master_register_block_core.sv
// I2C master register block: registers, command decode and receive FIFO.
// Depends on i2cm_pkg.
`default_nettype none

// Takes one item per clock unless the result side stalls: a register read, a
// register write or a byte received from the target. Each item gives exactly
// one result item through the input register, then the result register; the
// register state is updated in the same single pass, so back-to-back items
// see each other's effects. A full result register that is not taken holds
// the pipeline. The receive FIFO (FIFO_DEPTH bytes) is a circular buffer with
// a registered head read, and the write to the transmit data register reports
// the decoded bus action.
module i2c_master_register_block_core
    import i2cm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic            in_valid_reg;
    in_item_t        in_item_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;
    out_item_t       out_next;
    logic            advance;
    logic            step;

    logic [31:0]     ctrl_reg,   ctrl_next;
    logic [31:0]     status_reg, status_next;
    logic [31:0]     ien_reg,    ien_next;
    logic [31:0]     cfg_reg [5];
    logic [31:0]     cfg_next [5];
    logic [31:0]     fctrl_reg,  fctrl_next;
    logic [FILL_W-1:0] rx_fill_reg, rx_fill_next;
    logic [FILL_W-1:0] tx_fill_reg, tx_fill_next;
    logic [PTR_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic            open_reg,    open_next;
    logic [8:0]      pend_reg,    pend_next;
    logic            discard_reg, discard_next;

    logic [7:0]      rx_mem [FIFO_DEPTH];
    logic [7:0]      rx_head_reg;
    logic            rx_push;
    logic [PTR_W-1:0] wr_idx;
    logic [PTR_W:0]  wr_sum;
    logic [2:0]      cmd;
    logic [31:0]     wv;
    logic            acked;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    assign wv     = in_item_reg.write_value;
    assign acked  = in_item_reg.target_acked;
    assign cmd    = wv[10:8];
    assign wr_sum = (PTR_W+1)'(rd_ptr_reg) + (PTR_W+1)'(rx_fill_reg);
    assign wr_idx = (wr_sum >= (PTR_W+1)'(FIFO_DEPTH))
                    ? PTR_W'(wr_sum - (PTR_W+1)'(FIFO_DEPTH)) : PTR_W'(wr_sum);

    always_comb begin
        ctrl_next    = ctrl_reg;
        status_next  = status_reg;
        ien_next     = ien_reg;
        for (int i = 0; i < 5; i++) begin
            cfg_next[i] = cfg_reg[i];
        end
        fctrl_next   = fctrl_reg;
        rx_fill_next = rx_fill_reg;
        tx_fill_next = tx_fill_reg;
        rd_ptr_next  = rd_ptr_reg;
        open_next    = open_reg;
        pend_next    = pend_reg;
        discard_next = discard_reg;
        rx_push      = 1'b0;
        out_next     = '0;

        if (step) begin
            unique case (in_item_reg.operation)
                OP_READ: begin
                    unique case (in_item_reg.reg_offset)
                        OFS_VERSION: out_next.read_value = VERSION_VALUE;
                        OFS_PARAM:   out_next.read_value = PARAM_VALUE;
                        OFS_CTRL:    out_next.read_value = ctrl_reg;
                        OFS_STATUS:  out_next.read_value = status_reg;
                        OFS_IEN:     out_next.read_value = ien_reg;
                        OFS_CFG0:    out_next.read_value = cfg_reg[0];
                        OFS_CFG1:    out_next.read_value = cfg_reg[1];
                        OFS_CFG2:    out_next.read_value = cfg_reg[2];
                        OFS_CCFG0:   out_next.read_value = cfg_reg[3];
                        OFS_CCFG1:   out_next.read_value = cfg_reg[4];
                        OFS_FCTRL:   out_next.read_value = fctrl_reg;
                        OFS_FSTAT:   out_next.read_value = {16'(rx_fill_reg), 16'(tx_fill_reg)};
                        OFS_RXDATA: begin
                            if (rx_fill_reg != '0) begin
                                out_next.read_value = {24'd0, rx_head_reg};
                                rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1))
                                              ? '0 : rd_ptr_reg + PTR_W'(1);
                                rx_fill_next = rx_fill_reg - FILL_W'(1);
                                if (rx_fill_next == '0) begin
                                    status_next = status_next & ~ST_RDF;
                                end
                            end else begin
                                out_next.read_value = RX_EMPTY_DATA;
                            end
                        end
                        default: out_next.read_value = '0;
                    endcase
                end
                OP_WRITE: begin
                    unique case (in_item_reg.reg_offset)
                        OFS_CFG0:  cfg_next[0] = wv;
                        OFS_CFG1:  cfg_next[1] = wv;
                        OFS_CFG2:  cfg_next[2] = wv;
                        OFS_CCFG0: cfg_next[3] = wv;
                        OFS_CCFG1: cfg_next[4] = wv;
                        OFS_CTRL: begin
                            if (wv[CTRL_RST_BIT]) begin
                                ctrl_next    = '0;
                                status_next  = ST_RESET;
                                ien_next     = '0;
                                for (int i = 0; i < 5; i++) begin
                                    cfg_next[i] = '0;
                                end
                                fctrl_next   = '0;
                                rx_fill_next = '0;
                                tx_fill_next = '0;
                                rd_ptr_next  = '0;
                                open_next    = 1'b0;
                                pend_next    = '0;
                                discard_next = 1'b0;
                            end else begin
                                ctrl_next = wv & ~CTRL_CLR_MASK;
                                if (wv[CTRL_RXFLUSH_BIT]) begin
                                    rx_fill_next = '0;
                                    status_next  = status_next & ~ST_RDF;
                                end
                                status_next = status_next | ST_TDF;
                            end
                        end
                        OFS_STATUS: status_next = status_reg & ~(wv & ST_W1C);
                        OFS_IEN:    ien_next    = wv & IEN_MASK;
                        OFS_FCTRL:  fctrl_next  = wv & FCTRL_MASK;
                        OFS_TXDATA: begin
                            if (ctrl_reg[CTRL_EN_BIT]) begin
                                unique case (cmd) inside
                                    CMD_START, CMD_START_STOP: begin
                                        open_next    = 1'b1;
                                        pend_next    = '0;
                                        discard_next = 1'b0;
                                        status_next  = status_next & ~ST_BUSF;
                                        if (!acked) begin
                                            status_next = status_next | ST_NDF | ST_EPF;
                                        end
                                        out_next.bus_byte = wv[7:0];
                                        if (cmd == CMD_START_STOP) begin
                                            open_next   = 1'b0;
                                            status_next = status_next | ST_EPF | ST_BUSF;
                                            out_next.bus_action = ACT_START_STOP;
                                        end else begin
                                            out_next.bus_action = ACT_START;
                                        end
                                    end
                                    CMD_SEND: begin
                                        if (open_reg) begin
                                            if (!acked) begin
                                                status_next = status_next | ST_NDF | ST_EPF;
                                            end
                                            out_next.bus_action = ACT_SEND;
                                            out_next.bus_byte   = wv[7:0];
                                        end
                                    end
                                    CMD_RECV, CMD_DISCARD: begin
                                        if (open_reg) begin
                                            pend_next    = 9'(wv[7:0]) + 9'd1;
                                            discard_next = (cmd == CMD_DISCARD);
                                            out_next.bus_action = (cmd == CMD_DISCARD)
                                                                  ? ACT_DISCARD : ACT_RECV;
                                            out_next.receive_count = pend_next;
                                        end
                                    end
                                    CMD_STOP: begin
                                        if (open_reg) begin
                                            out_next.bus_action = ACT_STOP;
                                        end
                                        open_next    = 1'b0;
                                        pend_next    = '0;
                                        discard_next = 1'b0;
                                        status_next  = status_next | ST_EPF | ST_BUSF;
                                    end
                                    default: ;
                                endcase
                            end
                            if (tx_fill_reg < FILL_W'(FIFO_DEPTH)) begin
                                tx_fill_next = tx_fill_reg + FILL_W'(1);
                            end
                            if ((status_next & ST_TDF) != '0) begin
                                tx_fill_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_RECV: begin
                    if (open_reg && pend_reg != '0) begin
                        pend_next = pend_reg - 9'd1;
                        if (!discard_reg && rx_fill_reg < FILL_W'(FIFO_DEPTH)) begin
                            rx_push      = 1'b1;
                            rx_fill_next = rx_fill_reg + FILL_W'(1);
                            status_next  = status_next | ST_RDF;
                        end
                    end
                end
                default: ;
            endcase
            out_next.interrupt_line = (ien_next[0] && (status_next & ST_TDF) != '0) ||
                                      (ien_next[1] && (status_next & ST_RDF) != '0);
        end
    end

    // receive store: written at the tail, head read registered with write bypass
    always_ff @(posedge aclk) begin
        if (rx_push) begin
            rx_mem[wr_idx] <= in_item_reg.received_byte;
        end
        if (rx_push && wr_idx == rd_ptr_next) begin
            rx_head_reg <= in_item_reg.received_byte;
        end else begin
            rx_head_reg <= rx_mem[rd_ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_item_reg <= out_next;
        end
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            status_reg    <= ST_RESET;
            ien_reg       <= '0;
            for (int i = 0; i < 5; i++) begin
                cfg_reg[i] <= '0;
            end
            fctrl_reg     <= '0;
            rx_fill_reg   <= '0;
            tx_fill_reg   <= '0;
            rd_ptr_reg    <= '0;
            open_reg      <= 1'b0;
            pend_reg      <= '0;
            discard_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            ctrl_reg    <= ctrl_next;
            status_reg  <= status_next;
            ien_reg     <= ien_next;
            for (int i = 0; i < 5; i++) begin
                cfg_reg[i] <= cfg_next[i];
            end
            fctrl_reg   <= fctrl_next;
            rx_fill_reg <= rx_fill_next;
            tx_fill_reg <= tx_fill_next;
            rd_ptr_reg  <= rd_ptr_next;
            open_reg    <= open_next;
            pend_reg    <= pend_next;
            discard_reg <= discard_next;
        end
    end

endmodule

`default_nettype wire

### sv/i2cm_checker.sv
// Port-level checker for the I2C master register block, bound to the core.
// Depends on i2cm_pkg and i2c_master_register_block_core_assert.svh.
`default_nettype none

`include "i2c_master_register_block_core_assert.svh"

module i2cm_checker
    import i2cm_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    logic cnt_action;
    logic byte_action;

    assign cnt_action  = (m_item.bus_action == ACT_RECV) ||
                         (m_item.bus_action == ACT_DISCARD);
    assign byte_action = (m_item.bus_action == ACT_START) ||
                         (m_item.bus_action == ACT_START_STOP) ||
                         (m_item.bus_action == ACT_SEND);

    `I2CM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_item), "result item changed while stalled")
    `I2CM_ASSERT_NOW(a_action_no_data, aclk, aresetn,
        m_valid && m_item.bus_action != ACT_NONE, m_item.read_value == '0,
        "bus action reported with read data")
    `I2CM_ASSERT_NOW(a_count_only_recv, aclk, aresetn,
        m_valid && m_item.receive_count != '0, cnt_action,
        "receive count without receive action")
    `I2CM_ASSERT_NOW(a_recv_has_count, aclk, aresetn,
        m_valid && cnt_action, m_item.receive_count != '0,
        "receive action with zero count")
    `I2CM_ASSERT_NOW(a_byte_only_send, aclk, aresetn,
        m_valid && m_item.bus_byte != '0, byte_action,
        "bus byte without start or send action")

endmodule

bind i2c_master_register_block_core i2cm_checker u_i2cm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
